FILE: rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int CMD_W         = 3;
    localparam int WORD_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int DEFAULT_DEPTH = 16;

    // Command queue between front and back.
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LIST
    } back_state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [WORD_W-1:0] value;
    } op_t;

endpackage

`default_nettype wire

FILE: rtl/core/dq_if.sv
// Valid/ready channel interfaces for command and response words.
`timescale 1ns / 1ps
`default_nettype none

interface dq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [dq_pkg::CMD_W-1:0]         cmd;
    logic signed [dq_pkg::WORD_W-1:0] item_value;

    modport source (output valid, output cmd, output item_value, input ready);
    modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface dq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [dq_pkg::WORD_W-1:0] out_value;
    logic [dq_pkg::STATUS_W-1:0]      status;
    logic                             last_of_run;

    modport source (output valid, output out_value, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_value, input status, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/dq_front.sv
// Front end: accepts command words, drops unused codes, queues the rest.
`timescale 1ns / 1ps
`default_nettype none

module dq_front (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dq_cmd_if.sink     request,
    output logic       op_valid,
    input  wire logic  op_ready,
    output dq_pkg::op_t op
);
    import dq_pkg::*;

    op_t                  q_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] q_count_reg, q_count_next;
    logic                 accept, enq, deq, cmd_known;

    function automatic logic [OPQ_PTR_W-1:0] ptr_inc(input logic [OPQ_PTR_W-1:0] p);
        ptr_inc = (p == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : p + OPQ_PTR_W'(1);
    endfunction

    assign request.ready = (q_count_reg != OPQ_CNT_W'(OPQ_DEPTH));
    assign accept        = request.valid && request.ready;
    assign cmd_known     = (request.cmd <= CMD_W'(CMD_LIST));
    assign enq           = accept && cmd_known;

    assign op_valid = (q_count_reg != '0);
    assign deq      = op_valid && op_ready;
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next  = enq ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next  = deq ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        q_count_next = q_count_reg;
        if (enq && !deq)
        begin
            q_count_next = q_count_reg + OPQ_CNT_W'(1);
        end
        else if (deq && !enq)
        begin
            q_count_next = q_count_reg - OPQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= '{cmd: cmd_t'(request.cmd), value: request.item_value};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dq_back.sv
// Back end: ring pointers, storage access and the response register.
`timescale 1ns / 1ps
`default_nettype none

module dq_back #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        op_valid,
    output logic             op_ready,
    input  wire dq_pkg::op_t op,
    dq_rsp_if.source         response
);
    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    back_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_value_reg, load_value;
    status_t              out_status_reg, load_status;
    logic                 out_last_reg, load_last;
    logic                 out_load, out_free, full, empty, list_last;

    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0]    wr_data, rd_data;

    // (base + offset) mod DEPTH, both operands below DEPTH.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(offset);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        slot = s[IDX_W-1:0];
    endfunction

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || response.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = ((k_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        op_ready    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        wr_data     = $unsigned(op.value);
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        out_load    = 1'b0;
        load_value  = '0;
        load_status = STATUS_OK;
        load_last   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_ready = 1'b1;
                    case (op.cmd)
                        CMD_PUSH_FRONT,
                        CMD_PUSH_BACK:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                load_status = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                wr_en      = 1'b1;
                                if (op.cmd == CMD_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ?
                                                 IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
                                    wr_addr    = front_next;
                                end
                                else
                                begin
                                    wr_addr = slot(front_reg, count_reg);
                                end
                            end
                        end
                        CMD_POP_FRONT,
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_load    = 1'b1;
                                load_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_READ;
                                if (op.cmd == CMD_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = slot(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    rd_addr = slot(front_reg, count_reg - CNT_W'(1));
                                end
                            end
                        end
                        CMD_LIST:
                        begin
                            if (empty)
                            begin
                                out_load    = 1'b1;
                                load_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                k_next     = '0;
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_value = $signed(rd_data);
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_value = $signed(rd_data);
                    load_last  = list_last;
                    if (list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + CNT_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = slot(front_reg, k_next);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (response.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= load_value;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.out_value   = out_value_reg;
    assign response.status      = out_status_reg;
    assign response.last_of_run = out_last_reg;

    // Occupancy never passes the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above ring depth");

    // Front pointer stays inside the ring.
    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(front_reg) < SUM_W'(DEPTH))
        else $error("front index outside ring");

    // A list walk only runs over stored entries.
    a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST |-> (k_reg < count_reg))
        else $error("list index past entry count");

    // A read only starts from idle or inside a list walk.
    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ST_IDLE || state_reg == ST_LIST))
        else $error("storage read from wrong state");

    // Storage is written only by an accepted push.
    a_write_push: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (op_ready && (op.cmd == CMD_PUSH_FRONT || op.cmd == CMD_PUSH_BACK)))
        else $error("storage write without push");

endmodule

`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
// Top level of the double-ended queue: front end, command queue, back end.
// Path: a command word passes the front-end queue, then the back end loads the
//   response register; pops and lists also pass the registered storage read.
// Rate: pushes and status-only commands one per cycle, a list one word per cycle,
//   while the response side accepts; a pop holds the back end for its storage read.
// Reset (rst_n, async low) empties the queue: front index and count go to zero.
//   Ring storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dq_cmd_if.sink    request,
    dq_rsp_if.source  response
);
    import dq_pkg::*;

    // Command words cross from the front end to the back end through a
    // two-entry queue, so a stalled response blocks acceptance only once it is full.
    logic op_valid;
    logic op_ready;
    op_t  op;

    // Front end: takes command words, drops unused codes silently
    // (they produce no response word), queues the rest.
    dq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // Back end: owns the ring pointers and storage and runs one command at
    // a time; a list walks the ring one entry per cycle while the response
    // register drains.
    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .response (response)
    );

endmodule

`default_nettype wire

FILE: sim/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: directed table, back-pressure, random.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    import dq_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Command codes the block must swallow without answering.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 230;
    localparam int SEGMENT_ITEMS  = 30;
    localparam int MAX_GAP        = 19;
    localparam int HOLD_CYCLES    = 300;   // long response stall to back the block up
    localparam int FILL_PUSHES    = DEPTH + 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 3000;  // > HOLD_CYCLES + worst per-word gap, several times
    localparam int REPORT_LIMIT   = 10;

    // Traffic mix of a random segment: steers the fill level up, down, or around.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        status_t                  status;
        logic                     last;
    } answer_t;

    // One row of the directed script. Rows with typed set carry a hand-written
    // single answer (value 0, last set); others are checked by the predictor.
    typedef struct packed {
        logic [CMD_W-1:0]  code;
        logic [WORD_W-1:0] word;
        logic              typed;
        status_t           status;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dq_cmd_if request_ch ();
    dq_rsp_if response_ch ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the deque and the answers still owed by the block
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] shadow_ring [DEPTH];
    logic [IDX_W-1:0]         shadow_front;
    logic [CNT_W-1:0]         shadow_count;

    answer_t fresh_answers [$];    // answers of the word just accepted
    answer_t awaited_answers [$];  // everything still owed, oldest first

    int mismatches;
    bit no_gaps;       // segment with back-to-back traffic on both sides
    bit hold_request;  // asks the response side for one long stall
    bit word_taken;    // a response word was accepted at the last rising edge

    script_row_t script_rows [DIRECTED_ROWS];

    function void note_answer(input logic signed [WORD_W-1:0] value, input status_t status,
                              input logic last);
        fresh_answers.push_back('{value: value, status: status, last: last});
    endfunction

    // Applies one command to the shadow deque and lists the answers it causes.
    function void predict_answers(input logic [CMD_W-1:0] code,
                                  input logic signed [WORD_W-1:0] word);
        int k;
        int slot;
        fresh_answers.delete();
        case (code)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                begin
                    note_answer('0, STATUS_FULL, 1'b1);
                end
                else
                begin
                    if (code == CMD_PUSH_FRONT)
                    begin
                        shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                        slot = int'(shadow_front);
                    end
                    else
                    begin
                        slot = (int'(shadow_front) + int'(shadow_count)) % DEPTH;
                    end
                    shadow_ring[slot] = word;
                    shadow_count = shadow_count + 1'b1;
                    note_answer('0, STATUS_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    note_answer('0, STATUS_EMPTY, 1'b1);
                end
                else if (code == CMD_POP_FRONT)
                begin
                    note_answer(shadow_ring[shadow_front], STATUS_OK, 1'b1);
                    shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
                    shadow_count = shadow_count - 1'b1;
                end
                else
                begin
                    slot = (int'(shadow_front) + int'(shadow_count) - 1) % DEPTH;
                    note_answer(shadow_ring[slot], STATUS_OK, 1'b1);
                    shadow_count = shadow_count - 1'b1;
                end
            end
            CMD_LIST:
            begin
                if (shadow_count == 0)
                begin
                    note_answer('0, STATUS_EMPTY, 1'b1);
                end
                else
                begin
                    for (k = 0; k < int'(shadow_count); k++)
                    begin
                        slot = (int'(shadow_front) + k) % DEPTH;
                        note_answer(shadow_ring[slot], STATUS_OK, k == int'(shadow_count) - 1);
                    end
                end
            end
            default:
            begin
                // spare codes: no state change, no answer
            end
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(WORD_W - 1){1'b0}}};
            3:       return {1'b0, {(WORD_W - 1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_code(input mix_t mix);
        int roll;
        int push_odds;
        roll = $urandom_range(0, 99);
        push_odds = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
        if (roll < 3)
            return CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        if (roll < 13)
            return CMD_LIST;
        if ($urandom_range(0, 99) < push_odds)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Entered just after the previous acceptance (or while
    // idle); valid is only ever changed at a falling edge, once per edge.
    // ------------------------------------------------------------------
    task send_word(input logic [CMD_W-1:0] code, input logic signed [WORD_W-1:0] word,
                   input logic typed, input status_t typed_status);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.valid      <= 1'b1;
        request_ch.cmd        <= code;
        request_ch.item_value <= word;
        do
            @(posedge clk);
        while (!request_ch.ready);
        // accepted at this edge: the shadow deque moves on even for typed rows
        predict_answers(code, word);
        if (typed)
            awaited_answers.push_back('{value: '0, status: typed_status, last: 1'b1});
        else
            foreach (fresh_answers[k])
                awaited_answers.push_back(fresh_answers[k]);
    endtask

    task go_quiet();
        @(negedge clk);
        request_ch.valid <= 1'b0;
    endtask

    task wait_drained();
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: ready pattern driven at falling edges. A fresh stall
    // is drawn after each accepted word; a hold request overrides it.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (word_taken)
            begin
                stall_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            word_taken = 1'b0;
            if (stall_left > 0)
            begin
                response_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                response_ch.ready <= 1'b1;
            end
        end
    end

    // Checker: every accepted response word against the oldest owed answer.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            word_taken = 1'b1;
            if (awaited_answers.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: unexpected word: value %0d status %0d last %0b", $realtime,
                             response_ch.out_value, response_ch.status, response_ch.last_of_run);
                mismatches++;
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (response_ch.out_value !== want.value || response_ch.status !== want.status
                    || response_ch.last_of_run !== want.last)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: expected value %0d status %0d last %0b, got %0d %0d %0b",
                                 $realtime, want.value, want.status, want.last,
                                 response_ch.out_value, response_ch.status,
                                 response_ch.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int counted;
        int segment_left;
        mix_t mix;
        logic [CMD_W-1:0] code;

        rst_n                 = 1'b0;
        request_ch.valid      = 1'b0;
        request_ch.cmd        = CMD_PUSH_FRONT;
        request_ch.item_value = '0;
        mismatches            = 0;
        no_gaps               = 1'b0;
        hold_request          = 1'b0;
        word_taken            = 1'b0;
        shadow_front          = '0;
        shadow_count          = '0;
        foreach (shadow_ring[k])
            shadow_ring[k] = '0;

        // Empty-queue answers, extremes of the word, spare codes, single-entry
        // pops from both ends and a front push that wraps the front index.
        script_rows = '{
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, STATUS_EMPTY},
            '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STATUS_EMPTY},
            '{CMD_LIST,       32'h0000_0000, 1'b1, STATUS_EMPTY},
            '{CMD_SPARE_A,    32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, STATUS_OK},
            '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, STATUS_OK},
            '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, STATUS_OK},
            '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, STATUS_OK},
            '{CMD_LIST,       32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_SPARE_B,    32'hFFFF_FFFF, 1'b0, STATUS_OK},
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_POP_BACK,   32'hFFFF_FFFF, 1'b0, STATUS_OK},
            '{CMD_SPARE_C,    32'h5555_5555, 1'b0, STATUS_OK},
            '{CMD_LIST,       32'hFFFF_FFFF, 1'b0, STATUS_OK},
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_POP_BACK,   32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STATUS_EMPTY},
            '{CMD_LIST,       32'h0000_0000, 1'b1, STATUS_EMPTY},
            '{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, STATUS_OK},
            '{CMD_POP_BACK,   32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_PUSH_BACK,  32'h0000_0001, 1'b1, STATUS_OK},
            '{CMD_PUSH_FRONT, 32'hFFFF_FFFE, 1'b1, STATUS_OK},
            '{CMD_LIST,       32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, STATUS_OK},
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, STATUS_OK}
        };

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script_rows[r])
            send_word(script_rows[r].code, script_rows[r].word, script_rows[r].typed,
                      script_rows[r].status);
        go_quiet();
        wait_drained();

        // Back-pressure: the response side stalls for a long stretch while
        // pushes keep coming, so the command channel has to stall too; with more
        // pushes than the deque holds, it fills and refuses the extra pushes.
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        repeat (FILL_PUSHES)
            send_word($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word(),
                      1'b0, STATUS_OK);
        send_word(CMD_LIST, '0, 1'b0, STATUS_OK);

        // Random traffic in segments; each segment picks a fill bias and
        // whether both sides run without gaps. Spare codes are not counted.
        counted      = 0;
        segment_left = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (segment_left == 0)
            begin
                segment_left = SEGMENT_ITEMS;
                mix          = mix_t'($urandom_range(0, 2));
                no_gaps      = ($urandom_range(0, 3) == 0);
            end
            code = pick_code(mix);
            send_word(code, pick_word(), 1'b0, STATUS_OK);
            if (code <= CMD_LIST)
            begin
                counted++;
                segment_left--;
            end
        end

        go_quiet();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
